// File: hw/rtl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PRT_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define PRT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: hw/rtl/prt_pkg.sv
`default_nettype none

package prt_pkg;

    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 3;
    localparam int LIFE_W = 16;
    localparam int ADDR_W = 64;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [STAT_W-1:0] status_t;

    // command codes
    localparam cmd_t CMD_ADD    = 2'd0;
    localparam cmd_t CMD_REMOVE = 2'd1;
    localparam cmd_t CMD_CANCEL = 2'd2;
    localparam cmd_t CMD_TICK   = 2'd3;

    // status codes
    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_DUPLICATE = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_FOUND = 2'd3;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd4;

    // flags carried from cell to cell along with the command
    typedef struct packed {
        logic active;
        logic dup;
        logic have_free;
        logic found;
    } tok_flags_t;

    // command fields broadcast to every cell while an item is in flight
    typedef struct packed {
        cmd_t              cmd;
        logic [IDX_W-1:0]  slot_index;
        logic [LIFE_W-1:0] lifetime;
    } bcast_t;

endpackage

`default_nettype wire

// File: hw/rtl/prt_if.sv
`default_nettype none

// request channel
interface prt_req_if;
    logic                       valid;
    logic                       ready;
    logic [prt_pkg::CMD_W-1:0]  cmd;
    logic [prt_pkg::ADDR_W-1:0] dest_address;
    logic [prt_pkg::IDX_W-1:0]  slot_index;

    modport source (output valid, cmd, dest_address, slot_index, input ready);
    modport sink   (input valid, cmd, dest_address, slot_index, output ready);
endinterface

// response channel
interface prt_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [prt_pkg::STAT_W-1:0] status;
    logic [prt_pkg::IDX_W-1:0]  granted_slot;

    modport source (output valid, status, granted_slot, input ready);
    modport sink   (input valid, status, granted_slot, output ready);
endinterface

// lifetime register write channel
interface prt_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [prt_pkg::LIFE_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/prt_cell.sv
`default_nettype none

module prt_cell #(
    parameter int SLOTS     = 8,
    parameter int ADDR_BITS = 64,
    parameter int IDX       = 0,
    localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prt_pkg::bcast_t     bc,
    input  logic [ADDR_BITS-1:0] addr,
    input  prt_pkg::tok_flags_t tok_in,
    input  logic [SW-1:0]       hit_in,
    output prt_pkg::tok_flags_t tok_out,
    output logic [SW-1:0]       hit_out,
    input  logic                wr_en,
    input  logic [SW-1:0]       wr_sel
);
    import prt_pkg::*;

    localparam logic [SW-1:0] IDX_SW = SW'(IDX);

    logic                 valid_reg, valid_next;
    logic [ADDR_BITS-1:0] slot_addr_reg, slot_addr_next;
    logic [LIFE_W-1:0]    rem_reg, rem_next;
    tok_flags_t           tok_reg, tok_next;
    logic [SW-1:0]        hit_reg, hit_next;
    logic                 live;
    logic                 match;

    assign live  = valid_reg && (rem_reg != '0);
    assign match = (slot_addr_reg == addr);

    // slot update as the item passes, plus claim write from the end of the row
    always_comb
    begin
        valid_next     = valid_reg;
        slot_addr_next = slot_addr_reg;
        rem_next       = rem_reg;
        tok_next       = tok_in;
        hit_next       = hit_in;
        if (tok_in.active)
        begin
            case (bc.cmd)
                CMD_ADD:
                begin
                    // expired slot drops out before the duplicate check
                    valid_next = live;
                    if (live && match)
                        tok_next.dup = 1'b1;
                    if (!live)
                    begin
                        tok_next.have_free = 1'b1;
                        hit_next           = IDX_SW;
                    end
                end
                CMD_REMOVE:
                begin
                    if (!tok_in.found && valid_reg && match)
                    begin
                        valid_next     = 1'b0;
                        tok_next.found = 1'b1;
                        hit_next       = IDX_SW;
                    end
                end
                CMD_CANCEL:
                begin
                    if (int'(bc.slot_index) == IDX)
                        valid_next = 1'b0;
                end
                default:
                begin
                    if (rem_reg != '0)
                        rem_next = rem_reg - {{(LIFE_W-1){1'b0}}, 1'b1};
                end
            endcase
        end
        if (wr_en && (wr_sel == IDX_SW))
        begin
            valid_next     = 1'b1;
            slot_addr_next = addr;
            rem_next       = bc.lifetime;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    // slot payload and carried index
    always_ff @(posedge clk)
    begin
        slot_addr_reg <= slot_addr_next;
        rem_reg       <= rem_next;
        hit_reg       <= hit_next;
    end

    assign tok_out = tok_reg;
    assign hit_out = hit_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pending_request_table_with_expiry_top.sv
// channel   dir   payload                              handshake
// req       in    cmd, dest_address, slot_index        valid / ready
// rsp       out   status, granted_slot                 valid / ready
// cfg       in    data (lifetime_ticks)                valid / ready, ready always high
//
// each item walks the row of SLOTS cells one cell per cycle, from start_reg
// through the cell registers, and its result is registered before rsp; one item is in flight
// at a time and req.ready is high only while the row is empty.
// a stalled rsp holds the finished result, then the row is free again.
// reset clears all slot valid marks at once and loads lifetime_ticks with 4.
`default_nettype none
`include "assert_macros.svh"

module pending_request_table_with_expiry_top #(
    parameter int SLOTS     = 8,
    parameter int ADDR_BITS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    prt_req_if.sink   req,
    prt_rsp_if.source rsp,
    prt_cfg_if.sink   cfg
);
    import prt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]           state_reg, state_next;
    cmd_t                 cmd_reg;
    logic [IDX_W-1:0]     slot_index_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [LIFE_W-1:0]    lifetime_reg;
    logic                 start_reg;
    status_t              res_status_reg;
    logic [IDX_W-1:0]     res_slot_reg;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg;
    logic [IDX_W-1:0]     out_slot_reg;

    logic                 accept;
    logic                 out_free;
    logic                 fin;
    logic                 load_fin;
    logic                 load_res;
    logic                 wr_en;
    status_t              fin_status;
    logic [IDX_W-1:0]     fin_slot;
    logic [SW+IDX_W-1:0]  hit_ext;
    bcast_t               bc;
    logic [SLOTS:0]       active_vec;

    tok_flags_t           tok_chain [SLOTS+1];
    logic [SW-1:0]        hit_chain [SLOTS+1];

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign bc.cmd        = cmd_reg;
    assign bc.slot_index = slot_index_reg;
    assign bc.lifetime   = lifetime_reg;

    // row of slot cells
    assign tok_chain[0] = '{active: start_reg, default: 1'b0};
    assign hit_chain[0] = '0;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        prt_cell #(
            .SLOTS     (SLOTS),
            .ADDR_BITS (ADDR_BITS),
            .IDX       (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .bc      (bc),
            .addr    (addr_reg),
            .tok_in  (tok_chain[g]),
            .hit_in  (hit_chain[g]),
            .tok_out (tok_chain[g+1]),
            .hit_out (hit_chain[g+1]),
            .wr_en   (wr_en),
            .wr_sel  (hit_chain[SLOTS])
        );
    end

    assign fin     = tok_chain[SLOTS].active;
    assign hit_ext = {{IDX_W{1'b0}}, hit_chain[SLOTS]};

    // result once the item leaves the last cell
    always_comb
    begin
        fin_status = ST_DONE;
        fin_slot   = '0;
        wr_en      = 1'b0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (tok_chain[SLOTS].dup)
                    fin_status = ST_DUPLICATE;
                else if (!tok_chain[SLOTS].have_free)
                    fin_status = ST_FULL;
                else
                begin
                    fin_slot = hit_ext[IDX_W-1:0];
                    wr_en    = fin;
                end
            end
            CMD_REMOVE:
            begin
                if (tok_chain[SLOTS].found)
                    fin_slot = hit_ext[IDX_W-1:0];
                else
                    fin_status = ST_NOT_FOUND;
            end
            default:
            begin
                fin_status = ST_DONE;
            end
        endcase
    end

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        load_fin   = 1'b0;
        load_res   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (fin)
                begin
                    if (out_free)
                    begin
                        load_fin   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                        state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    load_res   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_fin || load_res)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            lifetime_reg  <= LIFETIME_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= accept;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                lifetime_reg <= cfg.data;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= req.cmd;
            slot_index_reg <= req.slot_index;
            addr_reg       <= req.dest_address[ADDR_BITS-1:0];
        end
        if (fin)
        begin
            res_status_reg <= fin_status;
            res_slot_reg   <= fin_slot;
        end
        if (load_fin)
        begin
            out_status_reg <= fin_status;
            out_slot_reg   <= fin_slot;
        end
        else if (load_res)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.granted_slot = out_slot_reg;

    // position of the item along the row
    always_comb
    begin
        for (int i = 0; i <= SLOTS; i++)
            active_vec[i] = tok_chain[i].active;
    end

    `PRT_ASSERT_IMPL(a_single_item, clk, rst_n, 1'b1, $onehot0(active_vec))
    `PRT_ASSERT_IMPL(a_fin_while_run, clk, rst_n, fin, state_reg == S_RUN)
    `PRT_ASSERT_NEXT(a_accept_enters_row, clk, rst_n, accept, tok_chain[0].active)
    `PRT_ASSERT_IMPL(a_hold_has_output, clk, rst_n, state_reg == S_HOLD, out_valid_reg)

endmodule

`default_nettype wire
